// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tdwc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdwc_pkg
// Types, constants and byte classification helpers of the display width
// counter.
// ----------------------------------------------------------------------------
package tdwc_pkg;

  localparam int unsigned WIDTH_BITS = 16;
  localparam int unsigned LA_DEPTH   = 4;
  localparam int unsigned FILL_BITS  = $clog2(LA_DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(LA_DEPTH + 1);

  typedef logic [7:0]            byte_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [WIDTH_BITS:0]   width_sum_t;
  typedef logic [FILL_BITS-1:0]  fill_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [2:0]            skip_t;
  typedef logic [1:0]            cols_t;

  localparam width_t WIDTH_MAX = '1;

  // Byte codes
  localparam byte_t CH_ESC   = 8'h1B;
  localparam byte_t CH_BEL   = 8'h07;
  localparam byte_t CH_LBRK  = 8'h5B;
  localparam byte_t CH_RBRK  = 8'h5D;
  localparam byte_t CH_BSLSH = 8'h5C;
  localparam byte_t MASK_F8  = 8'hF8;
  localparam byte_t MASK_F0  = 8'hF0;
  localparam byte_t MASK_E0  = 8'hE0;
  localparam byte_t MASK_C0  = 8'hC0;
  localparam byte_t LEAD4    = 8'hF0;
  localparam byte_t LEAD3    = 8'hE0;
  localparam byte_t LEAD2    = 8'hC0;
  localparam byte_t CONT     = 8'h80;

  // Parser modes, one-hot
  typedef enum logic [12:0] {
    MODE_IDLE      = 13'h0001,
    MODE_ESC       = 13'h0002,
    MODE_CSI       = 13'h0004,
    MODE_OSC       = 13'h0008,
    MODE_OSC_ESC   = 13'h0010,
    MODE_LEAD3     = 13'h0020,
    MODE_SKIP_IDLE = 13'h0040,
    MODE_SKIP_MOD  = 13'h0080,
    MODE_MOD       = 13'h0100,
    MODE_SKIP_ZWJ  = 13'h0200,
    MODE_ZWJ       = 13'h0400,
    MODE_ZWJ_NEXT  = 13'h0800,
    MODE_VS        = 13'h1000
  } mode_e;

  // What happens to the lookahead buffer after one byte
  typedef enum logic [1:0] {
    ACT_DROP,
    ACT_KEEP,
    ACT_REPLAY
  } act_e;

  // Columns of a complete 3-byte sequence
  function automatic cols_t three_byte_width(byte_t c, byte_t c1, byte_t c2);
    logic emoji;
    logic wide;
    emoji = (c == 8'hE2) && (
            ((c1 == 8'h9C) && (c2 inside {[8'h85:8'h88]})) ||
            ((c1 == 8'h98) && (c2 inside {[8'h80:8'h8F]})) ||
            ((c1 == 8'h9D) && (c2 inside {[8'h84:8'h8C]})) ||
            ((c1 == 8'h9A) && (c2 == 8'hA1)) ||
            ((c1 inside {8'h9A, 8'h9B}) && (c2 inside {[8'h80:8'hBF]})));
    wide  = ((c == 8'hE3) && (c1 inside {[8'h80:8'hBF]})) ||
            ((c == 8'hE4) && (c1 >= 8'hB8)) ||
            (c inside {[8'hE5:8'hE9]});
    return (emoji || wide) ? cols_t'(2) : cols_t'(1);
  endfunction

  // Expected byte at a position of a skin modifier, ZWJ or variation selector
  function automatic logic look_match(mode_e mode, fill_t pos, byte_t b);
    logic m;
    case (mode)
      MODE_MOD: begin
        case (pos)
          fill_t'(0): m = (b == 8'hF0);
          fill_t'(1): m = (b == 8'h9F);
          fill_t'(2): m = (b == 8'h8F);
          default:    m = (b inside {[8'hBB:8'hBF]});
        endcase
      end
      MODE_ZWJ: begin
        case (pos)
          fill_t'(0): m = (b == 8'hE2);
          fill_t'(1): m = (b == 8'h80);
          default:    m = (b == 8'h8D);
        endcase
      end
      default: begin
        case (pos)
          fill_t'(0): m = (b == 8'hEF);
          fill_t'(1): m = (b == 8'hB8);
          default:    m = (b inside {8'h8E, 8'h8F});
        endcase
      end
    endcase
    return m;
  endfunction

  // Check tried after a failed one
  function automatic mode_e next_check(mode_e mode);
    mode_e n;
    case (mode)
      MODE_MOD: n = MODE_ZWJ;
      MODE_ZWJ: n = MODE_VS;
      default:  n = MODE_IDLE;
    endcase
    return n;
  endfunction

endpackage

// ===== design/terminal_display_width_counter.sv =====
// ----------------------------------------------------------------------------
// terminal_display_width_counter
// Counts the terminal columns of a byte string, skipping ANSI escapes and
// sizing UTF-8 sequences, and reports the total at the end of the string.
// ----------------------------------------------------------------------------
// Usage: feed one byte per transaction on the input channel; has_byte_i low
// with is_last_i high is a bare end marker (empty string). The width of the
// string comes out as one result transaction after the transaction that
// carries is_last_i. Normal throughput is one byte per cycle; with no
// lookahead pending, the cycle that takes the last byte loads the result.
// The block stalls its input while it re-examines buffered bytes or an end
// of string waits: when a pending skin-modifier, ZWJ or variation-selector
// match fails, the up to four buffered bytes go back through the single
// byte parser, one byte per cycle, under each remaining check in turn. A
// string that ends inside an unresolved lookahead goes through the same
// replay, and the end of string also waits while the output register still
// holds an untaken result. The width saturates at its maximum and raises
// width_overflow_o. All state returns to reset after each result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module terminal_display_width_counter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           byte_value_i,
  input  logic                 has_byte_i,
  input  logic                 is_last_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          display_width_o,
  output logic                 width_overflow_o
);

  // --------------------------------------------------------------------------
  // State
  // la_q holds the lookahead bytes (positions below fill_q) followed by
  // bytes waiting for replay (positions fill_q to cnt_q - 1).
  // --------------------------------------------------------------------------
  tdwc_pkg::mode_e  mode_q, mode_d;
  tdwc_pkg::skip_t  skip_q, skip_d;
  tdwc_pkg::fill_t  fill_q, fill_d;
  tdwc_pkg::cnt_t   cnt_q, cnt_d;
  tdwc_pkg::byte_t  la_q [tdwc_pkg::LA_DEPTH];
  tdwc_pkg::byte_t  la_d [tdwc_pkg::LA_DEPTH];
  tdwc_pkg::width_t width_q, width_d;
  logic             sat_q, sat_d;
  logic             end_pend_q, end_pend_d;

  logic             out_valid_q, out_valid_d;
  tdwc_pkg::width_t out_width_q;
  logic             out_ovf_q;

  // --------------------------------------------------------------------------
  // Byte selection: replay bytes win over new input
  // --------------------------------------------------------------------------
  logic             from_buf;
  logic             in_acc;
  logic             byte_vld;
  tdwc_pkg::byte_t  cur_byte;
  tdwc_pkg::byte_t  la_ext [tdwc_pkg::LA_DEPTH];
  tdwc_pkg::cnt_t   cnt_ext;

  assign from_buf   = cnt_q > tdwc_pkg::cnt_t'(fill_q);
  assign in_stall_o = from_buf || end_pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign byte_vld   = from_buf || (in_acc && has_byte_i);
  assign cur_byte   = from_buf ? la_q[fill_q] : byte_value_i;

  // A new byte is appended behind the lookahead so all actions see one buffer
  always_comb begin
    for (int i = 0; i < tdwc_pkg::LA_DEPTH; i++) begin
      la_ext[i] = la_q[i];
    end
    cnt_ext = cnt_q;
    if (!from_buf) begin
      la_ext[fill_q] = byte_value_i;
      cnt_ext        = cnt_q + tdwc_pkg::cnt_t'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Single byte parser
  // --------------------------------------------------------------------------
  tdwc_pkg::act_e   act;
  tdwc_pkg::mode_e  b_mode;
  tdwc_pkg::skip_t  b_skip;
  tdwc_pkg::cols_t  b_cols;
  logic             b_match;
  logic             b_done;

  always_comb begin
    act     = tdwc_pkg::ACT_DROP;
    b_mode  = mode_q;
    b_skip  = skip_q;
    b_cols  = '0;
    b_match = tdwc_pkg::look_match(mode_q, fill_q, cur_byte);
    b_done  = 1'b0;
    case (mode_q)
      tdwc_pkg::MODE_ESC: begin
        if (cur_byte == tdwc_pkg::CH_LBRK) begin
          b_mode = tdwc_pkg::MODE_CSI;
        end else if (cur_byte == tdwc_pkg::CH_RBRK) begin
          b_mode = tdwc_pkg::MODE_OSC;
        end else begin
          b_mode = tdwc_pkg::MODE_IDLE;
        end
      end
      tdwc_pkg::MODE_CSI: begin
        if (cur_byte inside {[8'h40:8'h7E]}) begin
          b_mode = tdwc_pkg::MODE_IDLE;
        end
      end
      tdwc_pkg::MODE_OSC, tdwc_pkg::MODE_OSC_ESC: begin
        if ((mode_q == tdwc_pkg::MODE_OSC_ESC) && (cur_byte == tdwc_pkg::CH_BSLSH)) begin
          b_mode = tdwc_pkg::MODE_IDLE;
        end else if (cur_byte == tdwc_pkg::CH_BEL) begin
          b_mode = tdwc_pkg::MODE_IDLE;
        end else if (cur_byte == tdwc_pkg::CH_ESC) begin
          b_mode = tdwc_pkg::MODE_OSC_ESC;
        end else begin
          b_mode = tdwc_pkg::MODE_OSC;
        end
      end
      tdwc_pkg::MODE_LEAD3: begin
        if (fill_q == tdwc_pkg::fill_t'(2)) begin
          b_cols = tdwc_pkg::three_byte_width(la_ext[0], la_ext[1], cur_byte);
          b_mode = tdwc_pkg::MODE_IDLE;
        end else begin
          act = tdwc_pkg::ACT_KEEP;
        end
      end
      tdwc_pkg::MODE_SKIP_IDLE, tdwc_pkg::MODE_SKIP_MOD, tdwc_pkg::MODE_SKIP_ZWJ: begin
        b_skip = (skip_q == '0) ? '0 : skip_q - tdwc_pkg::skip_t'(1);
        if (b_skip == '0) begin
          case (mode_q)
            tdwc_pkg::MODE_SKIP_IDLE: b_mode = tdwc_pkg::MODE_IDLE;
            tdwc_pkg::MODE_SKIP_MOD:  b_mode = tdwc_pkg::MODE_MOD;
            default:                  b_mode = tdwc_pkg::MODE_ZWJ;
          endcase
        end
      end
      tdwc_pkg::MODE_MOD, tdwc_pkg::MODE_ZWJ, tdwc_pkg::MODE_VS: begin
        // last position of the pattern: 3 for the modifier, 2 otherwise
        b_done = (mode_q == tdwc_pkg::MODE_MOD) ? (fill_q == tdwc_pkg::fill_t'(3))
                                                : (fill_q == tdwc_pkg::fill_t'(2));
        if (b_match) begin
          if (b_done) begin
            case (mode_q)
              tdwc_pkg::MODE_MOD: b_mode = tdwc_pkg::MODE_ZWJ;
              tdwc_pkg::MODE_ZWJ: b_mode = tdwc_pkg::MODE_ZWJ_NEXT;
              default:            b_mode = tdwc_pkg::MODE_IDLE;
            endcase
          end else begin
            act = tdwc_pkg::ACT_KEEP;
          end
        end else begin
          act    = tdwc_pkg::ACT_REPLAY;
          b_mode = tdwc_pkg::next_check(mode_q);
        end
      end
      tdwc_pkg::MODE_ZWJ_NEXT: begin
        // joined character: skip its continuation bytes, then look for ZWJ
        if ((cur_byte & tdwc_pkg::MASK_F8) == tdwc_pkg::LEAD4) begin
          b_skip = tdwc_pkg::skip_t'(3);
        end else if ((cur_byte & tdwc_pkg::MASK_F0) == tdwc_pkg::LEAD3) begin
          b_skip = tdwc_pkg::skip_t'(2);
        end else if ((cur_byte & tdwc_pkg::MASK_E0) == tdwc_pkg::LEAD2) begin
          b_skip = tdwc_pkg::skip_t'(1);
        end else begin
          b_skip = '0;
        end
        b_mode = (b_skip == '0) ? tdwc_pkg::MODE_ZWJ : tdwc_pkg::MODE_SKIP_ZWJ;
      end
      default: begin
        // idle: start of a character
        b_mode = tdwc_pkg::MODE_IDLE;
        if (cur_byte == tdwc_pkg::CH_ESC) begin
          b_mode = tdwc_pkg::MODE_ESC;
        end else if ((cur_byte & tdwc_pkg::MASK_F8) == tdwc_pkg::LEAD4) begin
          b_cols = tdwc_pkg::cols_t'(2);
          b_skip = tdwc_pkg::skip_t'(3);
          b_mode = tdwc_pkg::MODE_SKIP_MOD;
        end else if ((cur_byte & tdwc_pkg::MASK_F0) == tdwc_pkg::LEAD3) begin
          act    = tdwc_pkg::ACT_KEEP;
          b_mode = tdwc_pkg::MODE_LEAD3;
        end else if ((cur_byte & tdwc_pkg::MASK_E0) == tdwc_pkg::LEAD2) begin
          b_cols = tdwc_pkg::cols_t'(1);
          b_skip = tdwc_pkg::skip_t'(1);
          b_mode = tdwc_pkg::MODE_SKIP_IDLE;
        end else if ((cur_byte & tdwc_pkg::MASK_C0) != tdwc_pkg::CONT) begin
          b_cols = tdwc_pkg::cols_t'(1);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State after the byte (identity when no byte this cycle)
  // --------------------------------------------------------------------------
  tdwc_pkg::mode_e  p_mode;
  tdwc_pkg::skip_t  p_skip;
  tdwc_pkg::fill_t  p_fill;
  tdwc_pkg::cnt_t   p_cnt;
  tdwc_pkg::byte_t  p_la [tdwc_pkg::LA_DEPTH];
  tdwc_pkg::cols_t  p_cols;
  tdwc_pkg::cnt_t   drop_n;
  tdwc_pkg::cnt_t   sh;

  assign drop_n = tdwc_pkg::cnt_t'(fill_q) + tdwc_pkg::cnt_t'(1);

  always_comb begin
    p_mode = mode_q;
    p_skip = skip_q;
    p_fill = fill_q;
    p_cnt  = cnt_q;
    p_cols = '0;
    sh     = '0;
    for (int i = 0; i < tdwc_pkg::LA_DEPTH; i++) begin
      p_la[i] = la_q[i];
    end
    if (byte_vld) begin
      p_mode = b_mode;
      p_skip = b_skip;
      p_cols = b_cols;
      for (int i = 0; i < tdwc_pkg::LA_DEPTH; i++) begin
        p_la[i] = la_ext[i];
      end
      p_cnt = cnt_ext;
      case (act)
        tdwc_pkg::ACT_KEEP: begin
          p_fill = fill_q + tdwc_pkg::fill_t'(1);
        end
        tdwc_pkg::ACT_REPLAY: begin
          p_fill = '0;
        end
        default: begin
          // consumed: lookahead and the byte leave the front of the buffer
          p_fill = '0;
          p_cnt  = cnt_ext - drop_n;
          for (int i = 0; i < tdwc_pkg::LA_DEPTH; i++) begin
            sh = tdwc_pkg::cnt_t'(i) + drop_n;
            if (sh < tdwc_pkg::cnt_t'(tdwc_pkg::LA_DEPTH)) begin
              p_la[i] = la_ext[sh[tdwc_pkg::FILL_BITS-1:0]];
            end
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // End of string
  // --------------------------------------------------------------------------
  logic                 end_now;
  logic                 p_queued;
  logic                 p_look;
  logic                 end_replay;
  logic                 out_free;
  logic                 fin;
  tdwc_pkg::cols_t      add_cols;
  tdwc_pkg::width_sum_t sum;
  tdwc_pkg::width_t     sum_sat;
  logic                 sum_ovf;

  assign end_now  = end_pend_q || (in_acc && is_last_i);
  assign p_queued = p_cnt > tdwc_pkg::cnt_t'(p_fill);
  assign p_look   = (p_mode == tdwc_pkg::MODE_MOD) || (p_mode == tdwc_pkg::MODE_ZWJ) ||
                    (p_mode == tdwc_pkg::MODE_VS);
  // pending match with buffered bytes: give them back under the next check
  assign end_replay = end_now && !p_queued && p_look && (p_fill != '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin        = end_now && !p_queued && !(p_look && (p_fill != '0)) && out_free;

  // a truncated 3-byte sequence counts one column
  assign add_cols = p_cols + tdwc_pkg::cols_t'(fin && (p_mode == tdwc_pkg::MODE_LEAD3));
  assign sum      = tdwc_pkg::width_sum_t'(width_q) + tdwc_pkg::width_sum_t'(add_cols);
  assign sum_ovf  = sum[tdwc_pkg::WIDTH_BITS];
  assign sum_sat  = sum_ovf ? tdwc_pkg::WIDTH_MAX : sum[tdwc_pkg::WIDTH_BITS-1:0];

  always_comb begin
    if (fin) begin
      mode_d     = tdwc_pkg::MODE_IDLE;
      skip_d     = '0;
      fill_d     = '0;
      cnt_d      = '0;
      width_d    = '0;
      sat_d      = 1'b0;
      end_pend_d = 1'b0;
    end else begin
      mode_d     = end_replay ? tdwc_pkg::next_check(p_mode) : p_mode;
      skip_d     = p_skip;
      fill_d     = end_replay ? '0 : p_fill;
      cnt_d      = p_cnt;
      width_d    = sum_sat;
      sat_d      = sat_q || sum_ovf;
      end_pend_d = end_now;
    end
    for (int i = 0; i < tdwc_pkg::LA_DEPTH; i++) begin
      la_d[i] = p_la[i];
    end
    out_valid_d = fin || (out_valid_q && out_stall_i);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tdwc_pkg::MODE_IDLE;
      skip_q      <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      width_q     <= '0;
      sat_q       <= 1'b0;
      end_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      skip_q      <= skip_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      width_q     <= width_d;
      sat_q       <= sat_d;
      end_pend_q  <= end_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tdwc_pkg::LA_DEPTH; i++) begin
      la_q[i] <= la_d[i];
    end
    if (fin) begin
      out_width_q <= sum_sat;
      out_ovf_q   <= sat_q || sum_ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign display_width_o  = 16'(out_width_q);
  assign width_overflow_o = out_ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_fill_le_cnt, clk_i, rst_ni,
    (tdwc_pkg::cnt_t'(fill_q) <= cnt_q) && (cnt_q <= tdwc_pkg::cnt_t'(tdwc_pkg::LA_DEPTH)),
    "lookahead fill beyond buffer count")
  `ASSERT_IMPLIES(a_fill_only_in_lookahead, clk_i, rst_ni,
    !((mode_q == tdwc_pkg::MODE_LEAD3) || (mode_q == tdwc_pkg::MODE_MOD) ||
      (mode_q == tdwc_pkg::MODE_ZWJ) || (mode_q == tdwc_pkg::MODE_VS)),
    fill_q == '0, "lookahead fill nonzero outside a lookahead mode")
  `ASSERT_IMPLIES(a_sat_at_max, clk_i, rst_ni, sat_q, width_q == tdwc_pkg::WIDTH_MAX,
    "saturation flag without a saturated width")
  `ASSERT_NEXT(a_end_resolves, clk_i, rst_ni, in_acc && is_last_i,
    in_stall_o || out_valid_o, "end of string neither pending nor reported")

endmodule
